FILE: design/srtrb_pkg.sv
// Shared types and codes for the serial port transmit/receive ring buffers.
// No dependencies; used by the ring and core modules.
`default_nettype none

package srtrb_pkg;

    typedef enum logic [1:0] {
        MODE_TX_PUSH   = 2'd0,
        MODE_RX_POP    = 2'd1,
        MODE_RX_ARRIVE = 2'd2,
        MODE_TX_REQ    = 2'd3
    } mode_t;

    typedef struct packed {
        logic ok;
        logic tx_src;
    } pend_t;

    localparam int unsigned BYTE_W = 8;

endpackage

`default_nettype wire

FILE: design/srtrb_ring.sv
// One byte ring buffer: synchronous memory plus read and write pointers,
// keeping one slot empty. Depends on srtrb_pkg for the byte width.
`default_nettype none

module srtrb_ring #(
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           push,
    input  wire logic [srtrb_pkg::BYTE_W-1:0]   wdata,
    input  wire logic                           pop,
    output logic                                full,
    output logic                                empty,
    output logic [srtrb_pkg::BYTE_W-1:0]        rdata_reg
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [srtrb_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [AW-1:0] rptr_reg, rptr_next;
    logic [AW-1:0] wptr_adv, rptr_adv;

    assign wptr_adv = (wptr_reg == LAST) ? '0 : wptr_reg + AW'(1);
    assign rptr_adv = (rptr_reg == LAST) ? '0 : rptr_reg + AW'(1);
    assign full     = (wptr_adv == rptr_reg);
    assign empty    = (wptr_reg == rptr_reg);

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        if (push && !full) begin
            wptr_next = wptr_adv;
        end
        if (pop && !empty) begin
            rptr_next = rptr_adv;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem[wptr_reg] <= wdata;
        end
        if (pop && !empty) begin
            rdata_reg <= mem[rptr_reg];
        end
    end

endmodule

`default_nettype wire

FILE: design/serial_tx_rx_ring_buffers_core.sv
// Serial port transmit and receive byte rings with transmit-interrupt enable.
// Depends on srtrb_pkg and srtrb_ring (one instance per direction).
//
// Each transfer on the s_ side is one event: transmit push, receive pop,
// received byte arrival or transmitter byte request, selected by s_tuser.
// Every event returns exactly one result on the m_ side. The pointer compare
// and memory access happen in the accept cycle, and the byte read into the
// ring's registered read data is captured into the output register once that
// register is free. The core takes no new event until the pending result has
// moved into the output register; the output register lets the next event
// enter while a result waits. Each ring holds at most DEPTH-1 bytes; pushes
// to a full ring and arrivals at a full ring return ok low and store nothing.
`default_nettype none

module serial_tx_rx_ring_buffers_core #(
    parameter int unsigned TX_DEPTH = 128,
    parameter int unsigned RX_DEPTH = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_in
    input  wire logic [1:0]  s_tuser,   // [1:0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] data_out, [8] tx_irq_enable, [15:9] zero
    output logic             m_tuser    // [0] ok
);

    srtrb_pkg::mode_t mode;
    logic             s_accept;
    logic             out_free;
    logic             load_out;

    logic tx_push, tx_pop, tx_full, tx_empty;
    logic rx_push, rx_pop, rx_full, rx_empty;
    logic [srtrb_pkg::BYTE_W-1:0] tx_rdata, rx_rdata;

    logic             busy_reg, busy_next;
    srtrb_pkg::pend_t pend_reg, pend_next;
    logic             irq_reg, irq_next;
    logic             pend_src_rx_reg, pend_src_rx_next;

    logic                         m_valid_reg, m_valid_next;
    logic                         m_ok_reg, m_ok_next;
    logic                         m_irq_reg, m_irq_next;
    logic [srtrb_pkg::BYTE_W-1:0] m_data_reg, m_data_next;

    assign mode     = srtrb_pkg::mode_t'(s_tuser);
    assign s_tready = !busy_reg;
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign load_out = busy_reg && out_free;

    srtrb_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (tx_push),
        .wdata     (s_tdata),
        .pop       (tx_pop),
        .full      (tx_full),
        .empty     (tx_empty),
        .rdata_reg (tx_rdata)
    );

    srtrb_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rx_push),
        .wdata     (s_tdata),
        .pop       (rx_pop),
        .full      (rx_full),
        .empty     (rx_empty),
        .rdata_reg (rx_rdata)
    );

    always_comb begin
        tx_push   = 1'b0;
        tx_pop    = 1'b0;
        rx_push   = 1'b0;
        rx_pop    = 1'b0;
        irq_next  = irq_reg;
        pend_next = pend_reg;
        busy_next = busy_reg;
        if (load_out) begin
            busy_next = 1'b0;
        end
        if (s_accept) begin
            busy_next        = 1'b1;
            pend_next.tx_src = 1'b0;
            case (mode)
                srtrb_pkg::MODE_TX_PUSH: begin
                    tx_push      = 1'b1;
                    pend_next.ok = !tx_full;
                    if (!tx_full) begin
                        irq_next = 1'b1;
                    end
                end
                srtrb_pkg::MODE_RX_POP: begin
                    rx_pop       = 1'b1;
                    pend_next.ok = !rx_empty;
                end
                srtrb_pkg::MODE_RX_ARRIVE: begin
                    rx_push      = 1'b1;
                    pend_next.ok = !rx_full;
                end
                srtrb_pkg::MODE_TX_REQ: begin
                    tx_pop           = 1'b1;
                    pend_next.ok     = !tx_empty;
                    pend_next.tx_src = 1'b1;
                    if (tx_empty) begin
                        irq_next = 1'b0;
                    end
                end
                default: begin
                    pend_next.ok = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_ok_next    = m_ok_reg;
        m_irq_next   = m_irq_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (load_out) begin
            m_valid_next = 1'b1;
            m_ok_next    = pend_reg.ok;
            m_irq_next   = irq_reg;
            m_data_next  = '0;
            if (pend_reg.ok && (mode_is_read(pend_reg))) begin
                m_data_next = pend_reg.tx_src ? tx_rdata : rx_rdata;
            end
        end
    end

    // pending read events: a receive pop or a transmit request
    function automatic logic mode_is_read(input srtrb_pkg::pend_t p);
        mode_is_read = p.tx_src || pend_src_rx_reg;
    endfunction

    assign pend_src_rx_next = s_accept ? (mode == srtrb_pkg::MODE_RX_POP) : pend_src_rx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            irq_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            irq_reg     <= irq_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg        <= pend_next;
        pend_src_rx_reg <= pend_src_rx_next;
        m_ok_reg        <= m_ok_next;
        m_irq_reg       <= m_irq_next;
        m_data_reg      <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_ok_reg;
    assign m_tdata  = {7'd0, m_irq_reg, m_data_reg};

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> busy_reg && !s_tready)
        else $error("accepted event did not occupy the core");

    a_push_sets_irq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (mode == srtrb_pkg::MODE_TX_PUSH) && !tx_full |=> irq_reg)
        else $error("accepted transmit push did not set interrupt enable");

    a_result_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && out_free |=> m_tvalid && !busy_reg)
        else $error("pending result not delivered to output register");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'd0)
        else $error("failed event returned nonzero data");
`endif

endmodule

`default_nettype wire

FILE: bench/ring_buffer_checker.sv
// Checker for the serial port ring buffer core: predicts each event's result
// and compares it with the result channel. Depends on srtrb_pkg only.
`timescale 1ns / 1ps

module ring_buffer_checker #(
    parameter int unsigned TX_DEPTH = 128,
    parameter int unsigned RX_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tuser,
    output int          mismatches,
    output int          outstanding,
    output int          checked,
    output int          refused
);

    typedef struct packed {
        srtrb_pkg::mode_t mode;
        logic             ok;
        logic [7:0]       data;
        logic             irq;
    } ring_result_t;

    logic [7:0]   tx_mem [TX_DEPTH];
    logic [7:0]   rx_mem [RX_DEPTH];
    int unsigned  tx_wr, tx_rd, rx_wr, rx_rd;
    logic         tx_irq;
    ring_result_t pending_results [$];
    int           n_bad, n_checked, n_refused;

    function automatic int unsigned bump(input int unsigned ptr, input int unsigned depth);
        return (ptr + 1 >= depth) ? 0 : ptr + 1;
    endfunction

    function automatic ring_result_t apply_serial_event(input srtrb_pkg::mode_t mode,
                                                        input logic [7:0] din);
        ring_result_t r;
        r = '0;
        r.mode = mode;
        case (mode)
            srtrb_pkg::MODE_TX_PUSH: begin
                if (bump(tx_wr, TX_DEPTH) != tx_rd) begin
                    tx_mem[tx_wr] = din;
                    tx_wr = bump(tx_wr, TX_DEPTH);
                    tx_irq = 1'b1;
                    r.ok = 1'b1;
                end
            end
            srtrb_pkg::MODE_RX_POP: begin
                if (rx_wr != rx_rd) begin
                    r.data = rx_mem[rx_rd];
                    rx_rd = bump(rx_rd, RX_DEPTH);
                    r.ok = 1'b1;
                end
            end
            srtrb_pkg::MODE_RX_ARRIVE: begin
                if (bump(rx_wr, RX_DEPTH) != rx_rd) begin
                    rx_mem[rx_wr] = din;
                    rx_wr = bump(rx_wr, RX_DEPTH);
                    r.ok = 1'b1;
                end
            end
            default: begin
                if (tx_wr == tx_rd) begin
                    tx_irq = 1'b0;
                end else begin
                    r.data = tx_mem[tx_rd];
                    tx_rd = bump(tx_rd, TX_DEPTH);
                    r.ok = 1'b1;
                end
            end
        endcase
        r.irq = tx_irq;
        return r;
    endfunction

    always @(posedge aclk) begin
        ring_result_t want;
        if (!aresetn) begin
            tx_wr = 0;
            tx_rd = 0;
            rx_wr = 0;
            rx_rd = 0;
            tx_irq = 1'b0;
            pending_results.delete();
            n_bad = 0;
            n_checked = 0;
            n_refused = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_checked++;
                if (pending_results.size() == 0) begin
                    if (n_bad < 10)
                        $display("%0t: result with nothing pending: ok=%0b data=%02h irq=%0b",
                                 $time, m_tuser, m_tdata[7:0], m_tdata[8]);
                    n_bad++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.ok || m_tdata[7:0] !== want.data ||
                        m_tdata[8] !== want.irq || m_tdata[15:9] !== 7'd0) begin
                        if (n_bad < 10) begin
                            $display("%0t: %s mismatch: expected ok=%0b data=%02h irq=%0b",
                                     $time, want.mode.name(), want.ok, want.data, want.irq);
                            $display("    got ok=%0b data=%02h irq=%0b pad=%02h",
                                     m_tuser, m_tdata[7:0], m_tdata[8], m_tdata[15:9]);
                        end
                        n_bad++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                want = apply_serial_event(srtrb_pkg::mode_t'(s_tuser), s_tdata);
                if (!want.ok)
                    n_refused++;
                pending_results.push_back(want);
            end
        end
        mismatches  <= n_bad;
        outstanding <= pending_results.size();
        checked     <= n_checked;
        refused     <= n_refused;
    end

endmodule

FILE: bench/serial_tx_rx_ring_buffers_core_test.sv
// Top of the ring buffer core bench: clock, reset, event stimulus, output
// back-pressure and verdict. Depends on srtrb_pkg, ring_buffer_checker and the core.
`timescale 1ns / 1ps

module serial_tx_rx_ring_buffers_core_test;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 8;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;

    int   mismatches, outstanding, checked, refused;
    int   n_sent;
    int   idle_cycles;
    logic gap_en;
    logic stall_en;
    logic hold_req;
    logic hold_taken;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    serial_tx_rx_ring_buffers_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ring_buffer_checker u_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked),
        .refused     (refused)
    );

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_event(input srtrb_pkg::mode_t mode, input logic [7:0] din);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= din;
        do @(posedge aclk); while (!s_tready);
        n_sent++;
        if (gap_en && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    task automatic run_mix(input int count, input int w_push, input int w_pop,
                           input int w_arrive, input int w_req);
        int               pick;
        srtrb_pkg::mode_t mode;
        repeat (count) begin
            pick = $urandom_range(0, w_push + w_pop + w_arrive + w_req - 1);
            if (pick < w_push)
                mode = srtrb_pkg::MODE_TX_PUSH;
            else if (pick < w_push + w_pop)
                mode = srtrb_pkg::MODE_RX_POP;
            else if (pick < w_push + w_pop + w_arrive)
                mode = srtrb_pkg::MODE_RX_ARRIVE;
            else
                mode = srtrb_pkg::MODE_TX_REQ;
            send_event(mode, random_byte());
        end
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // output back-pressure
    initial begin
        m_tready   <= 1'b0;
        hold_taken = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!stall_en) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("serial_tx_rx_ring_buffers_core_test: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tuser  <= srtrb_pkg::MODE_TX_PUSH;
        gap_en   = 1'b0;
        stall_en <= 1'b0;
        hold_req <= 1'b0;
        n_sent   = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty rings, flag set and clear, ignored data_in
        send_event(srtrb_pkg::MODE_TX_REQ, 8'h5A);
        send_event(srtrb_pkg::MODE_RX_POP, 8'hC3);
        send_event(srtrb_pkg::MODE_TX_PUSH, 8'h00);
        send_event(srtrb_pkg::MODE_TX_PUSH, 8'hFF);
        send_event(srtrb_pkg::MODE_TX_REQ, 8'hFF);
        send_event(srtrb_pkg::MODE_TX_PUSH, 8'h81);
        send_event(srtrb_pkg::MODE_TX_REQ, 8'h00);
        send_event(srtrb_pkg::MODE_TX_REQ, 8'h7E);
        send_event(srtrb_pkg::MODE_TX_REQ, 8'h00);
        send_event(srtrb_pkg::MODE_TX_REQ, 8'hA5);
        send_event(srtrb_pkg::MODE_RX_ARRIVE, 8'hFF);
        send_event(srtrb_pkg::MODE_RX_ARRIVE, 8'h00);
        send_event(srtrb_pkg::MODE_RX_ARRIVE, 8'hA5);
        send_event(srtrb_pkg::MODE_RX_ARRIVE, 8'h5A);
        send_event(srtrb_pkg::MODE_RX_POP, 8'hFF);
        send_event(srtrb_pkg::MODE_RX_POP, 8'h00);
        send_event(srtrb_pkg::MODE_RX_POP, 8'h81);
        send_event(srtrb_pkg::MODE_RX_POP, 8'h18);
        send_event(srtrb_pkg::MODE_RX_POP, 8'hE7);
        send_event(srtrb_pkg::MODE_TX_PUSH, 8'h3C);
        send_event(srtrb_pkg::MODE_TX_REQ, 8'hC3);
        send_event(srtrb_pkg::MODE_TX_REQ, 8'h66);
        send_event(srtrb_pkg::MODE_RX_ARRIVE, 8'h01);
        send_event(srtrb_pkg::MODE_RX_POP, 8'h99);

        gap_en = 1'b1;
        stall_en <= 1'b1;
        run_mix(160, 3, 2, 3, 2);

        // overfill transmit ring, starting under a long output hold-off
        hold_req <= 1'b1;
        repeat (135) send_event(srtrb_pkg::MODE_TX_PUSH, random_byte());
        s_tvalid <= 1'b0;
        wait_drained();
        gap_en = 1'b0;
        repeat (132) send_event(srtrb_pkg::MODE_TX_REQ, random_byte());

        gap_en = 1'b1;
        stall_en <= 1'b0;
        repeat (68) send_event(srtrb_pkg::MODE_RX_ARRIVE, random_byte());
        repeat (68) send_event(srtrb_pkg::MODE_RX_POP, random_byte());

        stall_en <= 1'b1;
        run_mix(150, 6, 1, 1, 2);
        run_mix(150, 1, 2, 6, 1);
        run_mix(60, 1, 3, 1, 3);

        gap_en = 1'b0;
        stall_en <= 1'b0;
        run_mix(130, 2, 2, 2, 2);
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("covered %0d events, %0d results checked, %0d refused on full or empty rings,",
                 n_sent, checked, refused);
        $display("with a long output hold-off, a drain pause and both rings overfilled");
        if (mismatches == 0 && outstanding == 0)
            $display("serial_tx_rx_ring_buffers_core_test: done, clean");
        else
            $display("serial_tx_rx_ring_buffers_core_test: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
design/srtrb_pkg.sv
design/srtrb_ring.sv
design/serial_tx_rx_ring_buffers_core.sv
bench/ring_buffer_checker.sv
bench/serial_tx_rx_ring_buffers_core_test.sv
